>>> rtl/aupic_pkg.sv
package aupic_pkg;

    localparam int MAX_DIM     = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int DIM_W       = 7;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DADDR_W     = 12;

    // Restoring divider: 16-bit dividend, 8-bit divisor, one bit per cycle.
    localparam int DIV_NUM_W  = 16;
    localparam int DIV_DEN_W  = 8;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_LINE_STRIDE   = 2'd2;
    localparam logic [1:0] REG_PARTLY_TRANSP = 2'd3;

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_EMIT
    } t_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/aupic_ram.sv
module aupic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/aupic_div.sv
module aupic_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [aupic_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [aupic_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_busy,
    output logic [aupic_pkg::DIV_NUM_W-1:0] o_quo,
    output logic [aupic_pkg::DIV_DEN_W-1:0] o_rem
);
    import aupic_pkg::*;

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_NUM_W-1:0]  r_quo;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W:0]    trial;
    logic                  ge;

    // The partial remainder stays below the divisor, so shifting in one
    // dividend bit needs just one extra bit.
    assign trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> rtl/argb_unpremultiply_image_copy_unit.sv
// ARGB un-premultiplying image copier.
// Input stream (s_axis): tuser selects the request, 0 loads the pixel in tdata
// into the image store, 1 asks for the next converted pixel. Loads are taken in
// one cycle each while idle; loads past width*height are dropped without effect.
// Output stream (m_axis): one transfer per accepted read once the whole image
// is loaded, carrying the converted pixel, its destination word address
// row*stride+column and tlast on the final pixel. Reads that come too early
// or after the last pixel produce no transfer.
// A read goes from its transfer through FETCH (store read, dividers started),
// DIV (bit-serial dividers for row/column and the three colors) and EMIT to
// the output register. Input is taken again once the result is in
// the output register, so the next read overlaps with a stalled output; a
// finished read waits while the output register is still full.
// Configuration goes through the APB port (width, height, stride, partly
// transparent mode at byte addresses 0, 4, 8, 12), written between images.
// Reset clears the load and read counters, the translucent flag and the output
// valid flag, sets the registers to 1, 1, 1, 0; the store keeps its contents.
module argb_unpremultiply_image_copy_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] pixel_out, [43:32] dst_addr, rest zero
    output logic        m_axis_tlast,   // last_pixel
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aupic_pkg::*;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_width, r_height, r_stride;
    logic             r_partly;
    logic [CNT_W-1:0] r_load_count, r_read_count;
    logic             r_transl;
    logic [31:0]      r_pix;
    logic             r_out_valid;
    logic [31:0]      r_out_pix;
    logic [DADDR_W-1:0] r_out_addr;
    logic             r_out_last;

    logic             cfg_we;
    logic             in_acc, is_load, is_read;
    logic [DIM_W-1:0] wc, hc, sc;
    logic [2*DIM_W-1:0] prod_wh;
    logic [CNT_W-1:0] total;
    logic             load_ok, read_ok;

    logic             ram_we, div_start, out_load, out_free;
    logic [31:0]      ram_rdata;

    logic [DIV_NUM_W-1:0] num_r, num_g, num_b;
    logic [DIV_NUM_W-1:0] q_row, q_r, q_g, q_b;
    logic [DIV_DEN_W-1:0] rem_row, rem_r, rem_g, rem_b;
    logic                 busy_row, busy_r, busy_g, busy_b;

    logic [7:0]       alpha, cr, cg, cb;
    logic [31:0]      conv_pix;
    logic [DIM_W+DADDR_W-1:0] row_prod;
    logic [DADDR_W-1:0] dst_addr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_stride <= DIM_W'(1);
            r_partly <= 1'b0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:   r_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_height <= pwdata[DIM_W-1:0];
                REG_LINE_STRIDE:   r_stride <= pwdata[DIM_W-1:0];
                REG_PARTLY_TRANSP: r_partly <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = 32'(r_width);
            REG_IMAGE_HEIGHT:  prdata = 32'(r_height);
            REG_LINE_STRIDE:   prdata = 32'(r_stride);
            REG_PARTLY_TRANSP: prdata = 32'(r_partly);
            default:           prdata = '0;
        endcase
    end

    // Image geometry.
    assign wc      = clamp_dim(r_width);
    assign hc      = clamp_dim(r_height);
    assign sc      = clamp_dim(r_stride);
    assign prod_wh = (2*DIM_W)'(wc) * (2*DIM_W)'(hc);
    assign total   = (prod_wh > (2*DIM_W)'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                          : CNT_W'(prod_wh);

    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign is_load = in_acc & (s_axis_tuser[0] == REQ_LOAD);
    assign is_read = in_acc & (s_axis_tuser[0] == REQ_READ);
    assign load_ok = r_load_count < total;
    assign read_ok = !load_ok && (r_read_count < total);
    assign out_free = !r_out_valid || m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (is_read && read_ok) n_state = S_FETCH;
            S_FETCH: n_state = S_DIV;
            S_DIV:   if (!busy_row) n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                ram_we        = is_load & load_ok;
            end
            S_FETCH: div_start = 1'b1;
            S_DIV:   ;
            S_EMIT:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_read_count <= '0;
            r_transl     <= 1'b0;
        end else begin
            if (ram_we) begin
                r_load_count <= r_load_count + CNT_W'(1);
                if (s_axis_tdata[31:24] != 8'h00 && s_axis_tdata[31:24] != 8'hFF) begin
                    r_transl <= 1'b1;
                end
            end
            if (out_load) begin
                r_read_count <= r_read_count + CNT_W'(1);
            end
        end
    end

    // The store is only read once every load is done, so a read never meets
    // a write to the same entry.
    aupic_ram #(
        .WIDTH(32),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_load_count[ADDR_W-1:0]),
        .i_wdata(s_axis_tdata),
        .i_raddr(r_read_count[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_pix <= ram_rdata;
        end
    end

    // c*255 as (c << 8) - c.
    assign num_r = {ram_rdata[23:16], 8'h00} - DIV_NUM_W'(ram_rdata[23:16]);
    assign num_g = {ram_rdata[15:8],  8'h00} - DIV_NUM_W'(ram_rdata[15:8]);
    assign num_b = {ram_rdata[7:0],   8'h00} - DIV_NUM_W'(ram_rdata[7:0]);

    aupic_div u_div_row (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(DIV_NUM_W'(r_read_count)), .i_den(DIV_DEN_W'(wc)),
        .o_busy(busy_row), .o_quo(q_row), .o_rem(rem_row)
    );

    aupic_div u_div_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_r), .i_den(ram_rdata[31:24]),
        .o_busy(busy_r), .o_quo(q_r), .o_rem(rem_r)
    );

    aupic_div u_div_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_g), .i_den(ram_rdata[31:24]),
        .o_busy(busy_g), .o_quo(q_g), .o_rem(rem_g)
    );

    aupic_div u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(num_b), .i_den(ram_rdata[31:24]),
        .o_busy(busy_b), .o_quo(q_b), .o_rem(rem_b)
    );

    // Conversion of the fetched pixel.
    assign alpha = r_pix[31:24];
    assign cr = (q_r[DIV_NUM_W-1:8] != '0) ? 8'hFF : q_r[7:0];
    assign cg = (q_g[DIV_NUM_W-1:8] != '0) ? 8'hFF : q_g[7:0];
    assign cb = (q_b[DIV_NUM_W-1:8] != '0) ? 8'hFF : q_b[7:0];

    always_comb begin
        if (r_transl) begin
            if (r_pix == 32'h0) begin
                conv_pix = 32'h0;
            end else if (alpha != 8'h00 && alpha != 8'hFF) begin
                conv_pix = {alpha, cr, cg, cb};
            end else begin
                conv_pix = r_pix | 32'hFF00_0000;
            end
        end else if (r_partly && r_pix == 32'h0) begin
            conv_pix = 32'h0;
        end else begin
            conv_pix = r_pix | 32'hFF00_0000;
        end
    end

    assign row_prod = (DIM_W+DADDR_W)'(q_row[DADDR_W-1:0]) * (DIM_W+DADDR_W)'(sc);
    assign dst_addr = row_prod[DADDR_W-1:0] + DADDR_W'(rem_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pix  <= conv_pix;
            r_out_addr <= dst_addr;
            r_out_last <= (r_read_count + CNT_W'(1)) == total;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out_addr, r_out_pix};
    assign m_axis_tlast  = r_out_last;

    // The store is written only while the image is still incomplete.
    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_load_count < total))
        else $error("store written past the image size");

    // All four dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy_row == busy_r) && (busy_r == busy_g) && (busy_g == busy_b))
        else $error("dividers out of step");

    // A result is only produced for a read of a fully loaded image.
    a_emit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_load_count >= total) && (r_read_count < total))
        else $error("result produced outside the read phase");

    // Each delivered result advances the read counter by exactly one.
    a_read_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_read_count == $past(r_read_count) + CNT_W'(1)))
        else $error("read counter did not advance");

endmodule

>>> tb/tb_argb_unpremultiply_image_copy_unit.sv
`timescale 1ns / 100ps

module tb_argb_unpremultiply_image_copy_unit;
    import aupic_pkg::*;

    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [31:0] pixel;
        logic [11:0] addr;
        logic        last;
    } t_pixel_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] pixel_in
    logic [0:0]  s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] pixel_out, [43:32] dst_addr, rest zero
    logic        m_axis_tlast;   // last_pixel
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the block's state, advanced on every accepted transfer.
    logic [31:0]  image_store [STORE_DEPTH];
    int unsigned  load_cnt;
    int unsigned  read_cnt;
    bit           translucent_seen;
    logic [6:0]   cfg_width;
    logic [6:0]   cfg_height;
    logic [6:0]   cfg_stride;
    logic         cfg_partly;

    t_pixel_out   expected_pixels[$];
    logic [31:0]  special_pixels[$];
    int unsigned  mismatch_cnt;
    int unsigned  burst_left;
    int unsigned  rx_cycle;
    int unsigned  hold_left;
    bit           hold_req;

    argb_unpremultiply_image_copy_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned dim_eff(logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > 7'(MAX_DIM)) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int unsigned image_total();
        int unsigned t;
        t = dim_eff(cfg_width) * dim_eff(cfg_height);
        return (t > STORE_DEPTH) ? STORE_DEPTH : t;
    endfunction

    function automatic logic [7:0] unscale_chan(logic [7:0] c, logic [7:0] a);
        int unsigned v;
        v = (32'(c) * 255) / 32'(a);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function automatic logic [31:0] unpremultiply(logic [31:0] p);
        logic [7:0] a;
        a = p[31:24];
        if (translucent_seen) begin
            if (p == 32'h0) return 32'h0;
            if (a != 8'h00 && a != 8'hFF) begin
                return {a, unscale_chan(p[23:16], a), unscale_chan(p[15:8], a),
                        unscale_chan(p[7:0], a)};
            end
            return p | 32'hFF00_0000;
        end
        if (cfg_partly && p == 32'h0) return 32'h0;
        return p | 32'hFF00_0000;
    endfunction

    function automatic void track_request(logic req, logic [31:0] pix);
        int unsigned tot;
        int unsigned w;
        t_pixel_out  res;
        tot = image_total();
        if (req == REQ_LOAD) begin
            if (load_cnt < tot) begin
                image_store[load_cnt] = pix;
                if (pix[31:24] != 8'h00 && pix[31:24] != 8'hFF) translucent_seen = 1'b1;
                load_cnt++;
            end
        end else if (load_cnt >= tot && read_cnt < tot) begin
            w         = dim_eff(cfg_width);
            res.pixel = unpremultiply(image_store[read_cnt]);
            res.addr  = 12'((read_cnt / w) * dim_eff(cfg_stride) + read_cnt % w);
            res.last  = (read_cnt + 1 == tot);
            expected_pixels.push_back(res);
            read_cnt++;
        end
    endfunction

    function automatic logic [31:0] random_pixel(bit allow_translucent);
        logic [7:0]  a;
        logic [23:0] rgb;
        if ($urandom_range(0, 7) == 0) return 32'h0;
        rgb = 24'($urandom);
        case ($urandom_range(0, 3))
            0: rgb = 24'h00_0000;
            1: rgb = 24'hFF_FFFF;
            default: ;
        endcase
        if (!allow_translucent) begin
            a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            case ($urandom_range(0, 5))
                0: a = 8'h00;
                1: a = 8'hFF;
                2: a = 8'h01;
                3: a = 8'hFE;
                default: a = 8'($urandom_range(1, 254));
            endcase
        end
        return {a, rgb};
    endfunction

    // Out-of-range encodings are used at random where they clamp to the same size.
    function automatic logic [6:0] encode_dim(int unsigned v);
        if (v == 1 && $urandom_range(0, 1)) return 7'd0;
        if (v == MAX_DIM && $urandom_range(0, 1)) return 7'($urandom_range(MAX_DIM + 1, 127));
        return 7'(v);
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_idx)
            REG_IMAGE_WIDTH:   cfg_width  = value[6:0];
            REG_IMAGE_HEIGHT:  cfg_height = value[6:0];
            REG_LINE_STRIDE:   cfg_stride = value[6:0];
            REG_PARTLY_TRANSP: cfg_partly = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shape(logic [6:0] w_raw, logic [6:0] h_raw, logic [6:0] s_raw,
                             logic pt);
        apb_write(REG_IMAGE_WIDTH, 32'(w_raw));
        apb_write(REG_IMAGE_HEIGHT, 32'(h_raw));
        apb_write(REG_LINE_STRIDE, 32'(s_raw));
        apb_write(REG_PARTLY_TRANSP, 32'(pt));
    endtask

    // Sender works in bursts; a gap of idle cycles may come before each new burst.
    task automatic send_item(logic req, logic [31:0] pix);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        track_request(req, pix);
        burst_left--;
    endtask

    task automatic wait_drained();
        int unsigned waited;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_pixels.size() != 0) begin
            note_mismatch($sformatf("%0d expected pixels never arrived",
                                    expected_pixels.size()));
            expected_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Loads until the image is complete, then reads it out; early reads and
    // extra loads are mixed in as noise, and a few surplus reads close the phase.
    task automatic run_image_phase(logic [6:0] w_raw, logic [6:0] h_raw, logic [6:0] s_raw,
                                   logic pt, bit allow_translucent, bit hold);
        int unsigned tot;
        set_shape(w_raw, h_raw, s_raw, pt);
        tot = image_total();
        if (hold) hold_req = 1'b1;
        while (load_cnt < tot) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(REQ_READ, $urandom);
            end else if (special_pixels.size() != 0) begin
                send_item(REQ_LOAD, special_pixels.pop_front());
            end else begin
                send_item(REQ_LOAD, random_pixel(allow_translucent));
            end
        end
        while (read_cnt < tot) begin
            if ($urandom_range(0, 9) == 0) send_item(REQ_LOAD, $urandom);
            else send_item(REQ_READ, $urandom);
        end
        repeat ($urandom_range(1, 3)) send_item(REQ_READ, $urandom);
        wait_drained();
    endtask

    task automatic random_shape(output logic [6:0] w_raw, output logic [6:0] h_raw);
        int unsigned want_total;
        int unsigned w;
        int unsigned h;
        want_total = load_cnt + $urandom_range(10, 40);
        do begin
            w = $urandom_range(1, MAX_DIM);
            h = (want_total + w - 1) / w;
        end while (h > MAX_DIM);
        w_raw = encode_dim(w);
        h_raw = encode_dim(h);
    endtask

    // Zero dimensions act as 1; an early read, an extra translucent load and a
    // surplus read must all leave no trace.
    task automatic test_opaque_corners();
        set_shape(7'd0, 7'd2, 7'd0, 1'b0);
        send_item(REQ_READ, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, 32'h0000_0000);
        send_item(REQ_LOAD, 32'hFF12_3456);
        send_item(REQ_LOAD, 32'h80AB_CDEF);
        send_item(REQ_READ, 32'h0000_0000);
        send_item(REQ_READ, 32'h1234_5678);
        send_item(REQ_READ, 32'h0000_0000);
        wait_drained();
    endtask

    // Opaque image in partly transparent mode, with a stride below the width.
    task automatic test_partly_transparent_zero();
        set_shape(7'd2, 7'd3, 7'd1, 1'b1);
        send_item(REQ_LOAD, 32'h0000_0000);
        send_item(REQ_LOAD, 32'h00FF_FFFF);
        send_item(REQ_LOAD, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, 32'h0000_0000);
        repeat (5) send_item(REQ_READ, $urandom);
        wait_drained();
    endtask

    task automatic test_random_opaque();
        logic [6:0] w_raw;
        logic [6:0] h_raw;
        run_image_phase(7'd0, 7'd127, 7'($urandom_range(0, 127)), 1'($urandom), 1'b0, 1'b0);
        repeat (3) begin
            random_shape(w_raw, h_raw);
            run_image_phase(w_raw, h_raw, 7'($urandom_range(0, 127)), 1'($urandom),
                            1'b0, 1'b0);
        end
    endtask

    // First translucent pixels: alpha 1 and 254, clamping at 255, zero pixels.
    task automatic test_unpremultiply_corners();
        logic [6:0] h_raw;
        special_pixels = '{32'h01FF_FFFF, 32'h0100_0000, 32'hFE80_8080, 32'h80FF_0040,
                           32'h0000_0000, 32'hFF00_0000, 32'h0012_3456, 32'hFEFE_FEFE};
        h_raw = 7'((load_cnt + 20 + MAX_DIM - 1) / MAX_DIM);
        run_image_phase(7'd127, h_raw, 7'd127, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_translucent();
        logic [6:0] w_raw;
        logic [6:0] h_raw;
        repeat (4) begin
            random_shape(w_raw, h_raw);
            run_image_phase(w_raw, h_raw, 7'($urandom_range(0, 127)), 1'($urandom),
                            1'b1, 1'b0);
        end
    endtask

    // The receiver holds off long enough for reads to back up into the input.
    task automatic test_output_backpressure();
        logic [6:0] w_raw;
        logic [6:0] h_raw;
        random_shape(w_raw, h_raw);
        run_image_phase(w_raw, h_raw, 7'($urandom_range(0, 127)), 1'($urandom), 1'b1, 1'b1);
    endtask

    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_cycle % 4 == 0);
                default: m_axis_tready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pixel_out got;
        t_pixel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pixel = m_axis_tdata[31:0];
            got.addr  = m_axis_tdata[43:32];
            got.last  = m_axis_tlast;
            if (expected_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer pixel=%h addr=%0d last=%b",
                                        got.pixel, got.addr, got.last));
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel !== want.pixel || got.addr !== want.addr
                    || got.last !== want.last) begin
                    note_mismatch($sformatf(
                        "expected pixel=%h addr=%0d last=%b, got pixel=%h addr=%0d last=%b",
                        want.pixel, want.addr, want.last, got.pixel, got.addr, got.last));
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = 32'h0;
        s_axis_tuser     = REQ_LOAD;
        m_axis_tready    = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = 4'h0;
        pwdata           = 32'h0;
        load_cnt         = 0;
        read_cnt         = 0;
        translucent_seen = 1'b0;
        cfg_width        = 7'd1;
        cfg_height       = 7'd1;
        cfg_stride       = 7'd1;
        cfg_partly       = 1'b0;
        mismatch_cnt     = 0;
        burst_left       = 0;
        rx_cycle         = 0;
        hold_left        = 0;
        hold_req         = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_opaque_corners();
        test_partly_transparent_zero();
        test_random_opaque();
        test_unpremultiply_corners();
        test_random_translucent();
        test_output_backpressure();

        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/aupic_pkg.sv
rtl/aupic_ram.sv
rtl/aupic_div.sv
rtl/argb_unpremultiply_image_copy_unit.sv
tb/tb_argb_unpremultiply_image_copy_unit.sv
